/* rtl/skf_pkg.sv */
// types and constants shared by the scalar kalman filter modules
`default_nettype none

package skf_pkg;

  // fixed-point constants, unsigned with 30 fraction bits (ONE_Q30 is q1.30)
  localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
  localparam logic [63:0] HALF_Q30 = 64'h0000_0000_2000_0000;

  // configuration register indexes
  localparam logic [1:0] REG_PROCESS_NOISE     = 2'd0;
  localparam logic [1:0] REG_MEASUREMENT_NOISE = 2'd1;

  // reset values of the configuration registers
  localparam logic [30:0] PROCESS_NOISE_RESET     = 31'd1073742;
  localparam logic [30:0] MEASUREMENT_NOISE_RESET = 31'd5368709;

  // divider runs one quotient bit per cycle
  localparam logic [4:0] DIV_LAST = 5'd30;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL_GAIN,
    ST_MUL_COV,
    ST_FINISH
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic div_step;
    logic mul_gain;
    logic mul_cov;
    logic finish;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic out_busy;
  } status_t;

endpackage

`default_nettype wire

/* rtl/skf_ctrl.sv */
// controller state machine sequencing divide, multiply and update steps
`default_nettype none

module skf_ctrl
  import skf_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t     state;
  state_t     state_next;
  logic [4:0] count;

  // state register and divider step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (state == ST_DIV) begin
        count <= count + 5'd1;
      end else begin
        count <= '0;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_DIV;
      end
      ST_DIV: begin
        if (count == DIV_LAST) state_next = ST_MUL_GAIN;
      end
      ST_MUL_GAIN: state_next = ST_MUL_COV;
      ST_MUL_COV:  state_next = ST_FINISH;
      ST_FINISH: begin
        if (!status.out_busy) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_DIV:      cmd.div_step = 1'b1;
      ST_MUL_GAIN: cmd.mul_gain = 1'b1;
      ST_MUL_COV:  cmd.mul_cov  = 1'b1;
      ST_FINISH:   cmd.finish   = !status.out_busy;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/skf_datapath.sv */
// datapath: filter state, restoring divider, shared multiplier, output word
`default_nettype none

module skf_datapath
  import skf_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               write_enable,
  input  wire logic [1:0]         write_index,
  input  wire logic [30:0]        write_data,
  input  wire logic signed [31:0] measured_angle,
  input  wire cmd_t               cmd,
  output status_t                 status,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      filtered_angle,
  output logic [30:0]             gain
);

  logic [30:0] process_noise;
  logic [30:0] measurement_noise;
  logic [31:0] estimate;
  logic [31:0] error_covariance;

  logic [31:0] pp;
  logic [32:0] den;
  logic        den_zero;
  logic [32:0] rem;
  logic [30:0] num_bits;
  logic [30:0] quo;
  logic [32:0] mag;
  logic        neg;
  logic [63:0] prod;

  // prediction, divisor and innovation for the captured word
  logic [32:0] pp_sum;
  logic [31:0] pp_sat;
  logic [32:0] den_sum;
  logic [32:0] innov;

  always_comb begin
    pp_sum  = {1'b0, error_covariance} + {2'b00, process_noise};
    pp_sat  = pp_sum[32] ? 32'hFFFF_FFFF : pp_sum[31:0];
    den_sum = {1'b0, pp_sat} + {2'b00, measurement_noise};
    innov   = {measured_angle[31], measured_angle} - {estimate[31], estimate};
  end

  // one restoring divider step
  logic [33:0] rem_shift;
  logic [33:0] rem_diff;
  logic        q_bit;

  always_comb begin
    rem_shift = {rem, num_bits[30]};
    rem_diff  = rem_shift - {1'b0, den};
    q_bit     = (rem_shift >= {1'b0, den}) && !den_zero;
  end

  // shared multiplier operands
  logic [32:0] mul_a;
  logic [30:0] mul_b;

  always_comb begin
    if (cmd.mul_cov) begin
      mul_a = {1'b0, pp};
      mul_b = ONE_Q30 - quo;
    end else begin
      mul_a = mag;
      mul_b = quo;
    end
  end

  // rounding of the registered product and estimate update
  logic [63:0] prod_rnd;
  logic [33:0] est_wide;
  logic [33:0] delta_wide;
  logic [33:0] est_new;

  always_comb begin
    prod_rnd   = prod + HALF_Q30;
    est_wide   = {{2{estimate[31]}}, estimate};
    delta_wide = {1'b0, prod_rnd[62:30]};
    est_new    = neg ? (est_wide - delta_wide) : (est_wide + delta_wide);
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      process_noise     <= PROCESS_NOISE_RESET;
      measurement_noise <= MEASUREMENT_NOISE_RESET;
    end else if (write_enable) begin
      case (write_index)
        REG_PROCESS_NOISE:     process_noise     <= write_data;
        REG_MEASUREMENT_NOISE: measurement_noise <= write_data;
        default: begin
        end
      endcase
    end
  end

  // filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      estimate         <= '0;
      error_covariance <= {1'b0, ONE_Q30};
    end else begin
      if (cmd.mul_cov) estimate <= est_new[31:0];
      if (cmd.finish)  error_covariance <= prod_rnd[61:30];
    end
  end

  // divider, innovation and multiplier registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pp       <= pp_sat;
      den      <= den_sum;
      den_zero <= (den_sum == 33'd0);
      rem      <= {2'b00, pp_sat[31:1]};
      num_bits <= {pp_sat[0], 30'd0};
      quo      <= '0;
      neg      <= innov[32];
      mag      <= innov[32] ? (33'd0 - innov) : innov;
    end
    if (cmd.div_step) begin
      rem      <= q_bit ? rem_diff[32:0] : rem_shift[32:0];
      num_bits <= {num_bits[29:0], 1'b0};
      quo      <= {quo[29:0], q_bit};
    end
    if (cmd.mul_gain || cmd.mul_cov) begin
      prod <= {31'd0, mul_a} * {33'd0, mul_b};
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      filtered_angle <= estimate;
      gain           <= quo;
    end
  end

  assign status.out_busy = out_valid && !out_ready;

endmodule

`default_nettype wire

/* rtl/scalar_kalman_filter.sv */
// top level of the scalar kalman filter: controller plus datapath
// a word runs through the 31-step restoring divider, gain and covariance multiplies
// and the finish state, which waits until the previous output word is taken;
// new input is taken only in idle, also while the previous output word still waits
// rst (synchronous) sets estimate to zero, covariance to one, noise regs to defaults
`default_nettype none

module scalar_kalman_filter
  import skf_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               write_enable,
  input  wire logic [1:0]         write_index,
  input  wire logic [30:0]        write_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] measured_angle,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      filtered_angle,
  output logic [30:0]             gain
);

  cmd_t    cmd;
  status_t status;

  // sequencing
  skf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // arithmetic and state
  skf_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .write_enable   (write_enable),
    .write_index    (write_index),
    .write_data     (write_data),
    .measured_angle (measured_angle),
    .cmd            (cmd),
    .status         (status),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .filtered_angle (filtered_angle),
    .gain           (gain)
  );

endmodule

`default_nettype wire

/* dv/tb.sv */
// self-checking testbench for the scalar kalman filter
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import skf_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned WORDS_PER_PHASE = 62;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned REPORT_LIMIT = 50;
  // indexes past the register list, a write there changes nothing
  localparam logic [1:0] REG_SPARE_2 = 2'd2;
  localparam logic [1:0] REG_SPARE_3 = 2'd3;

  // full-scale and sign corners of a q16.16 angle
  localparam logic [31:0] CORNER_ANGLES [12] = '{
    32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
    32'hFFFF_FFFF, 32'h0000_0001, 32'h0001_0000, 32'hFFFF_0000,
    32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0000, 32'h0000_0000
  };

  typedef struct packed {
    logic [31:0] angle;
    logic [30:0] gain;
  } filt_word_t;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_COIN,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic write_enable = 1'b0;
  logic [1:0] write_index = '0;
  logic [30:0] write_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] measured_angle = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] filtered_angle;
  logic [30:0] gain;

  // filter state and noise settings as the block should hold them
  logic [31:0] est_angle = '0;
  logic [31:0] est_cov = {1'b0, ONE_Q30};
  logic [30:0] noise_q = PROCESS_NOISE_RESET;
  logic [30:0] noise_r = MEASUREMENT_NOISE_RESET;

  logic [31:0] sample_q[$];
  filt_word_t estimate_q[$];
  filt_word_t want;
  logic [31:0] walk_angle = '0;

  int unsigned errors = 0;
  int unsigned words_in = 0;
  int unsigned words_out = 0;
  int unsigned zero_gain_cnt = 0;
  int unsigned unity_gain_cnt = 0;
  int unsigned cfg_writes = 0;
  int unsigned cycle_cnt = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned ready_left = 0;
  rx_mode_t ready_mode = RX_ALWAYS;
  logic [7:0] ready_tick = '0;

  scalar_kalman_filter i_dut (
    .clk            (clk),
    .rst            (rst),
    .write_enable   (write_enable),
    .write_index    (write_index),
    .write_data     (write_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .measured_angle (measured_angle),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .filtered_angle (filtered_angle),
    .gain           (gain)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // one filter step: predict covariance, form gain, update estimate and covariance
  function automatic filt_word_t kalman_predict(logic [31:0] z);
    logic [32:0] cov_sum;
    logic [31:0] p_pred;
    logic [33:0] divisor;
    logic [63:0] k;
    logic signed [32:0] innov;
    logic [63:0] mag;
    logic [63:0] delta;
    logic [63:0] next_cov;
    filt_word_t res;
    // predicted covariance saturates at the top of the unsigned range
    cov_sum = {1'b0, est_cov} + {2'b0, noise_q};
    p_pred = cov_sum[32] ? 32'hFFFF_FFFF : cov_sum[31:0];
    divisor = {2'b0, p_pred} + {3'b0, noise_r};
    // zero divisor gives zero gain
    if (divisor == '0) k = '0;
    else k = ({32'd0, p_pred} << 30) / {30'd0, divisor};
    // magnitude step rounded half away from zero, sign from the innovation
    innov = $signed({z[31], z}) - $signed({est_angle[31], est_angle});
    mag = {31'd0, innov[32] ? -innov : innov};
    delta = (mag * k + HALF_Q30) >> 30;
    est_angle = innov[32] ? est_angle - delta[31:0] : est_angle + delta[31:0];
    next_cov = (({33'd0, ONE_Q30} - k) * {32'd0, p_pred} + HALF_Q30) >> 30;
    est_cov = next_cov[31:0];
    res.angle = est_angle;
    res.gain = k[30:0];
    return res;
  endfunction

  // mostly a slowly drifting angle with sensor noise, sometimes jumps and junk
  function automatic logic [31:0] pick_angle();
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel < 13) begin
      walk_angle = walk_angle + 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
      return walk_angle + 32'($urandom_range(0, 1 << 17)) - 32'(1 << 16);
    end else if (sel < 17) begin
      return $urandom;
    end else if (sel == 17) begin
      return CORNER_ANGLES[$urandom_range(0, 11)];
    end
    walk_angle = $urandom;
    return walk_angle;
  endfunction

  // noise setting: zero, one, full scale, any value, or small (the likeliest)
  function automatic logic [30:0] rand_noise();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return ONE_Q30;
      2: return 31'h7FFF_FFFF;
      3: return 31'($urandom);
      default: return 31'($urandom_range(1, 1 << 25));
    endcase
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [30:0] data);
    @(posedge clk);
    write_enable <= 1'b1;
    write_index <= idx;
    write_data <= data;
    @(posedge clk);
    write_enable <= 1'b0;
    if (idx == REG_PROCESS_NOISE) noise_q = data;
    else if (idx == REG_MEASUREMENT_NOISE) noise_r = data;
    cfg_writes++;
  endtask

  // hold the sender until every pending word has come back
  task automatic drain();
    @(negedge clk);
    while (sample_q.size() != 0 || in_valid || estimate_q.size() != 0) @(negedge clk);
  endtask

  // stimulus sequence
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    // corner angles with the reset noise settings
    foreach (CORNER_ANGLES[i]) sample_q.push_back(CORNER_ANGLES[i]);
    drain();
    // no noise at all: full gain once, then the divisor goes to zero
    write_reg(REG_PROCESS_NOISE, '0);
    write_reg(REG_MEASUREMENT_NOISE, '0);
    write_reg(REG_SPARE_2, 31'($urandom));
    write_reg(REG_SPARE_3, 31'($urandom));
    repeat (5) sample_q.push_back(pick_angle());
    drain();
    // largest noise values
    write_reg(REG_PROCESS_NOISE, 31'h7FFF_FFFF);
    write_reg(REG_MEASUREMENT_NOISE, 31'h7FFF_FFFF);
    sample_q.push_back(32'h8000_0000);
    sample_q.push_back(32'h7FFF_FFFF);
    repeat (2) sample_q.push_back(pick_angle());
    drain();
    // gain pinned at one, output follows the measurement
    write_reg(REG_PROCESS_NOISE, ONE_Q30);
    write_reg(REG_MEASUREMENT_NOISE, '0);
    repeat (3) sample_q.push_back(pick_angle());
    drain();
    // random noise settings, each phase split by a full drain
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_reg(REG_PROCESS_NOISE, rand_noise());
      write_reg(REG_MEASUREMENT_NOISE, rand_noise());
      if ($urandom_range(0, 3) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, 31'($urandom));
      repeat (WORDS_PER_PHASE / 2) sample_q.push_back(pick_angle());
      drain();
      repeat (WORDS_PER_PHASE - WORDS_PER_PHASE / 2) sample_q.push_back(pick_angle());
      drain();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d angle words filtered under %0d noise settings, %0d register writes",
             words_in, RANDOM_PHASES + 4, cfg_writes);
    $display("gain was zero %0d times and one %0d times, %0d mismatches",
             zero_gain_cnt, unity_gain_cnt, errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // input driver: bursts of words with random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (sample_q.size() == 0) begin
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        measured_angle <= sample_q.pop_front();
        if (burst_left == 0) begin
          burst_left <= $urandom_range(0, 15);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 45);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // output stall pattern, switching to a randomly chosen mode when its countdown runs out
  always @(posedge clk) begin
    ready_tick <= ready_tick + 8'd1;
    if (ready_left == 0) begin
      ready_mode <= rx_mode_t'($urandom_range(0, 3));
      ready_left <= $urandom_range(40, 300);
    end else begin
      ready_left <= ready_left - 1;
    end
    case (ready_mode)
      RX_ALWAYS: out_ready <= 1'b1;
      RX_COIN: out_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready <= ($urandom_range(0, 7) == 0);
      default: out_ready <= (ready_tick[3:2] != 2'd0);
    endcase
  end

  // expected estimate for each accepted angle word
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      estimate_q.push_back(kalman_predict(measured_angle));
      words_in++;
    end
  end

  // compare each output word with the oldest expected estimate
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      words_out++;
      if (estimate_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: output word with nothing pending, angle %h gain %h",
                   $time, filtered_angle, gain);
      end else begin
        want = estimate_q.pop_front();
        if (filtered_angle !== want.angle) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("%0t: filtered_angle mismatch, expected %h actual %h",
                     $time, want.angle, filtered_angle);
        end
        if (gain !== want.gain) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("%0t: gain mismatch, expected %h actual %h", $time, want.gain, gain);
        end
        if (want.gain == '0) zero_gain_cnt++;
        if (want.gain == ONE_Q30) unity_gain_cnt++;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d words outstanding",
               $time, cycle_cnt, estimate_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

endmodule
